/* rtl/core/sha512_pkg.sv */
// sha512_pkg: constants, tables and round functions of the sha-512 / sha-384 engine
// used by the channel interfaces and the engine top level
package sha512_pkg;

  typedef logic [63:0] word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROUND,
    ST_FOLD,
    ST_PAD,
    ST_EMIT
  } state_t;

  localparam int unsigned ROUNDS = 80;
  localparam logic [6:0] LEN_OFFSET = 7'd112;

  function automatic word_t iv_word(input logic mode, input logic [2:0] idx);
    word_t r;
    r = '0;
    if (!mode) begin
      case (idx)
        3'd0: r = 64'h6a09e667f3bcc908;
        3'd1: r = 64'hbb67ae8584caa73b;
        3'd2: r = 64'h3c6ef372fe94f82b;
        3'd3: r = 64'ha54ff53a5f1d36f1;
        3'd4: r = 64'h510e527fade682d1;
        3'd5: r = 64'h9b05688c2b3e6c1f;
        3'd6: r = 64'h1f83d9abfb41bd6b;
        3'd7: r = 64'h5be0cd19137e2179;
        default: r = '0;
      endcase
    end else begin
      case (idx)
        3'd0: r = 64'hcbbb9d5dc1059ed8;
        3'd1: r = 64'h629a292a367cd507;
        3'd2: r = 64'h9159015a3070dd17;
        3'd3: r = 64'h152fecd8f70e5939;
        3'd4: r = 64'h67332667ffc00b31;
        3'd5: r = 64'h8eb44a8768581511;
        3'd6: r = 64'hdb0c2e0d64f98fa7;
        3'd7: r = 64'h47b5481dbefa4fa4;
        default: r = '0;
      endcase
    end
    return r;
  endfunction

  localparam word_t ROUND_K [ROUNDS] = '{
    64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
    64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
    64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
    64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
    64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
    64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
    64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
    64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
    64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
    64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
    64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
    64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
    64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
    64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
    64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
    64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
    64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
    64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
    64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
    64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
  };

  function automatic word_t rotr(input word_t x, input int unsigned n);
    return (x >> n) | (x << (64 - n));
  endfunction

  function automatic word_t sig0(input word_t x);
    return rotr(x, 1) ^ rotr(x, 8) ^ (x >> 7);
  endfunction

  function automatic word_t sig1(input word_t x);
    return rotr(x, 19) ^ rotr(x, 61) ^ (x >> 6);
  endfunction

  function automatic word_t bsig0(input word_t x);
    return rotr(x, 28) ^ rotr(x, 34) ^ rotr(x, 39);
  endfunction

  function automatic word_t bsig1(input word_t x);
    return rotr(x, 14) ^ rotr(x, 18) ^ rotr(x, 41);
  endfunction

endpackage

/* rtl/core/sha512_in_if.sv */
// sha512_in_if: message item channel (valid / ready / payload)
// depends on sha512_pkg
interface sha512_in_if;
  logic                 valid;
  logic                 ready;
  sha512_pkg::word_t    msg_word;
  logic [3:0]           valid_bytes;
  logic                 last_word;

  modport source (output valid, msg_word, valid_bytes, last_word, input ready);
  modport sink (input valid, msg_word, valid_bytes, last_word, output ready);
endinterface

/* rtl/core/sha512_out_if.sv */
// sha512_out_if: digest item channel (valid / ready / payload)
// depends on sha512_pkg
interface sha512_out_if;
  logic                 valid;
  logic                 ready;
  sha512_pkg::word_t    digest_word;
  logic [2:0]           word_index;
  logic                 digest_done;

  modport source (output valid, digest_word, word_index, digest_done, input ready);
  modport sink (input valid, digest_word, word_index, digest_done, output ready);
endinterface

/* rtl/core/sha512_hash_engine_top.sv */
// sha512_hash_engine_top: sha-512 / sha-384 engine with one shared round unit
// depends on sha512_pkg, sha512_in_if, sha512_out_if
//
// An item is accepted only while the engine is idle. Its bytes then go into the block
// register one per cycle, pausing while a full block is compressed, and the item is then
// closed. Each time the block fills, the round unit runs 80 rounds, one per cycle, and
// then folds the working values into the chaining values. On a last item, padding
// places the marker and zero bytes one at a time up to the next word boundary, then
// whole words up to byte 112, then the length words. When the marker lands past
// byte 111, the rest of the block is padded and compressed first. A second block then
// follows, with 14 zero words and the length. Then come 8 digest items (sha-384: 6),
// one per cycle while the sink is ready. A mode write (cfg_we high for one cycle while
// idle) selects the mode, reloads its initial values and drops any message in progress.
module sha512_hash_engine_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic                cfg_wdata,
  sha512_in_if.sink           in_ch,
  sha512_out_if.source        out_ch
);

  sha512_pkg::state_t state, state_next;
  sha512_pkg::word_t  chain [8];
  sha512_pkg::word_t  wv [8];
  sha512_pkg::word_t  sched [16];
  logic               mode;
  logic [6:0]         fill;
  logic [63:0]        count;
  logic [6:0]         rnd;
  logic [3:0]         nleft;
  sha512_pkg::word_t  hold;
  logic               last_pend;
  logic               pad_on;
  logic               padded;
  logic [2:0]         eidx;
  logic [2:0]         words;
  sha512_pkg::word_t  wk;

  // round unit, message schedule one round ahead
  sha512_pkg::word_t w_next, t1, t2;
  logic [6:0] rn;
  logic [3:0] ri;
  always_comb begin
    rn = 7'd0;
    if (state == sha512_pkg::ST_ROUND && rnd != 7'(sha512_pkg::ROUNDS - 1)) rn = rnd + 7'd1;
    ri = rn[3:0];
    if (rn < 7'd16) begin
      w_next = sched[ri];
    end else begin
      w_next = sched[ri] + sha512_pkg::sig0(sched[ri + 4'd1]) + sched[ri + 4'd9]
               + sha512_pkg::sig1(sched[ri + 4'd14]);
    end
    t1 = wv[7] + sha512_pkg::bsig1(wv[4]) + (wv[6] ^ (wv[4] & (wv[5] ^ wv[6]))) + wk;
    t2 = sha512_pkg::bsig0(wv[0]) + ((wv[0] & wv[1]) | (wv[2] & (wv[0] | wv[1])));
  end

  assign words = mode ? 3'd5 : 3'd7;

  // byte insert helper
  logic [3:0] wi;
  logic [5:0] sh;
  sha512_pkg::word_t bmask, bval;
  always_comb begin
    wi = fill[6:3];
    sh = 6'd56 - {fill[2:0], 3'b000};
    bmask = ~(64'hff << sh);
    bval = {56'd0, hold[63:56]} << sh;
  end

  always_comb begin
    state_next = state;
    if (cfg_we) begin
      state_next = sha512_pkg::ST_IDLE;
    end else begin
      case (state)
        sha512_pkg::ST_IDLE: if (in_ch.valid) state_next = sha512_pkg::ST_LOAD;
        sha512_pkg::ST_LOAD: begin
          if (nleft != 4'd0) begin
            if (fill == 7'd127) state_next = sha512_pkg::ST_ROUND;
          end else begin
            state_next = last_pend ? sha512_pkg::ST_PAD : sha512_pkg::ST_IDLE;
          end
        end
        sha512_pkg::ST_ROUND: begin
          if (rnd == 7'(sha512_pkg::ROUNDS - 1)) state_next = sha512_pkg::ST_FOLD;
        end
        sha512_pkg::ST_FOLD: begin
          if (padded) state_next = sha512_pkg::ST_EMIT;
          else if (pad_on) state_next = sha512_pkg::ST_PAD;
          else state_next = sha512_pkg::ST_LOAD;
        end
        sha512_pkg::ST_PAD: begin
          if (fill[2:0] != 3'd0) begin
            if (fill == 7'd127) state_next = sha512_pkg::ST_ROUND;
          end else if (fill == sha512_pkg::LEN_OFFSET && !hold[63]) begin
            state_next = sha512_pkg::ST_ROUND;
          end else if (wi == 4'd15) begin
            state_next = sha512_pkg::ST_ROUND;
          end
        end
        sha512_pkg::ST_EMIT: if (out_ch.ready && eidx == words) state_next = sha512_pkg::ST_IDLE;
        default: state_next = sha512_pkg::ST_IDLE;
      endcase
    end
  end

  always_comb begin
    in_ch.ready = (state == sha512_pkg::ST_IDLE) && !cfg_we;
    out_ch.valid = (state == sha512_pkg::ST_EMIT);
    out_ch.digest_word = chain[eidx];
    out_ch.word_index = eidx;
    out_ch.digest_done = (eidx == words);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sha512_pkg::ST_IDLE;
      mode <= 1'b0;
      fill <= '0;
      count <= '0;
      rnd <= '0;
      nleft <= '0;
      hold <= '0;
      last_pend <= 1'b0;
      pad_on <= 1'b0;
      padded <= 1'b0;
      eidx <= '0;
      for (int i = 0; i < 8; i++) chain[i] <= sha512_pkg::iv_word(1'b0, 3'(i));
    end else begin
      state <= state_next;
      wk <= w_next + sha512_pkg::ROUND_K[rn];
      if (cfg_we) begin
        mode <= cfg_wdata;
        fill <= '0;
        count <= '0;
        rnd <= '0;
        nleft <= '0;
        last_pend <= 1'b0;
        pad_on <= 1'b0;
        padded <= 1'b0;
        for (int i = 0; i < 8; i++) chain[i] <= sha512_pkg::iv_word(cfg_wdata, 3'(i));
      end else begin
        case (state)
          sha512_pkg::ST_IDLE: begin
            if (in_ch.valid) begin
              hold <= in_ch.msg_word;
              nleft <= (in_ch.valid_bytes > 4'd8) ? 4'd8 : in_ch.valid_bytes;
              last_pend <= in_ch.last_word;
              pad_on <= 1'b0;
              padded <= 1'b0;
            end
          end
          sha512_pkg::ST_LOAD: begin
            if (nleft != 4'd0) begin
              sched[wi] <= (sched[wi] & bmask) | bval;
              hold <= hold << 8;
              nleft <= nleft - 4'd1;
              count <= count + 64'd1;
              fill <= fill + 7'd1;
            end else if (last_pend) begin
              hold <= 64'h8000_0000_0000_0000;
              pad_on <= 1'b1;
            end
          end
          sha512_pkg::ST_ROUND: begin
            if (rn >= 7'd16) sched[ri] <= w_next;
            wv[7] <= wv[6]; wv[6] <= wv[5]; wv[5] <= wv[4]; wv[4] <= wv[3] + t1;
            wv[3] <= wv[2]; wv[2] <= wv[1]; wv[1] <= wv[0]; wv[0] <= t1 + t2;
            rnd <= (rnd == 7'(sha512_pkg::ROUNDS - 1)) ? 7'd0 : rnd + 7'd1;
          end
          sha512_pkg::ST_FOLD: begin
            for (int i = 0; i < 8; i++) chain[i] <= chain[i] + wv[i];
            eidx <= '0;
          end
          sha512_pkg::ST_PAD: begin
            // hold carries the 0x80 marker until it is placed, then zeros
            if (fill[2:0] != 3'd0) begin
              sched[wi] <= (sched[wi] & bmask) | bval;
              hold <= hold << 8;
              fill <= fill + 7'd1;
            end else if (fill == sha512_pkg::LEN_OFFSET && !hold[63]) begin
              sched[14] <= {61'd0, count[63:61]};
              sched[15] <= {count[60:0], 3'b000};
              padded <= 1'b1;
            end else begin
              sched[wi] <= hold;
              hold <= '0;
              fill <= fill + 7'd8;
            end
          end
          sha512_pkg::ST_EMIT: begin
            if (out_ch.ready) begin
              eidx <= eidx + 3'd1;
              if (eidx == words) begin
                fill <= '0;
                count <= '0;
                pad_on <= 1'b0;
                padded <= 1'b0;
                for (int i = 0; i < 8; i++) chain[i] <= sha512_pkg::iv_word(mode, 3'(i));
              end
            end
          end
          default: ;
        endcase
        if (state != sha512_pkg::ST_ROUND && state_next == sha512_pkg::ST_ROUND) begin
          for (int i = 0; i < 8; i++) wv[i] <= chain[i];
        end
      end
    end
  end

endmodule

/* verif/tb_sha512_hash_engine_top.sv */
// testbench for sha512_hash_engine_top: streams messages, predicts sha-512 / sha-384 digests
// depends on sha512_pkg, sha512_in_if, sha512_out_if and the engine top level
`timescale 1ns / 1ps

module tb_sha512_hash_engine_top;

  typedef struct packed {
    sha512_pkg::word_t dword;
    logic [2:0]        idx;
    logic              done;
  } digest_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_wdata = 1'b0;

  sha512_in_if in_ch ();
  sha512_out_if out_ch ();

  sha512_hash_engine_top uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  always #5 clk = ~clk;

  localparam sha512_pkg::word_t IV512 [8] = '{
    64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
    64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179};
  localparam sha512_pkg::word_t IV384 [8] = '{
    64'hcbbb9d5dc1059ed8, 64'h629a292a367cd507, 64'h9159015a3070dd17, 64'h152fecd8f70e5939,
    64'h67332667ffc00b31, 64'h8eb44a8768581511, 64'hdb0c2e0d64f98fa7, 64'h47b5481dbefa4fa4};
  localparam sha512_pkg::word_t KTAB [80] = '{
    64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
    64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
    64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
    64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
    64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
    64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
    64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
    64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
    64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
    64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
    64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
    64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
    64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
    64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
    64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
    64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
    64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
    64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
    64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
    64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817};

  logic               mode_m;
  sha512_pkg::word_t  hash_m [8];
  sha512_pkg::word_t  blk_m [16];
  logic [6:0]         fill_m;
  logic [63:0]        len_m;
  digest_item_t       digest_q [$];

  int errors = 0;
  int items_sent = 0;
  int digests_seen = 0;
  int messages = 0;
  int src_idle = 0;
  int snk_idle = 0;

  function automatic sha512_pkg::word_t ror64(sha512_pkg::word_t x, int n);
    return (x >> n) | (x << (64 - n));
  endfunction

  task automatic fold_block();
    sha512_pkg::word_t w [16];
    sha512_pkg::word_t v [8];
    sha512_pkg::word_t s0, s1, t1, t2, wr;
    int r;
    for (int i = 0; i < 16; i++) w[i] = blk_m[i];
    for (int i = 0; i < 8; i++) v[i] = hash_m[i];
    for (r = 0; r < 80; r++) begin
      if (r < 16) begin
        wr = w[r];
      end else begin
        s0 = ror64(w[(r - 15) & 15], 1) ^ ror64(w[(r - 15) & 15], 8) ^ (w[(r - 15) & 15] >> 7);
        s1 = ror64(w[(r - 2) & 15], 19) ^ ror64(w[(r - 2) & 15], 61) ^ (w[(r - 2) & 15] >> 6);
        wr = w[r & 15] + s0 + w[(r - 7) & 15] + s1;
        w[r & 15] = wr;
      end
      t1 = v[7] + (ror64(v[4], 14) ^ ror64(v[4], 18) ^ ror64(v[4], 41))
         + (v[6] ^ (v[4] & (v[5] ^ v[6]))) + KTAB[r] + wr;
      t2 = (ror64(v[0], 28) ^ ror64(v[0], 34) ^ ror64(v[0], 39))
         + ((v[0] & v[1]) | (v[2] & (v[0] | v[1])));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_m[i] += v[i];
  endtask

  task automatic put_byte(logic [7:0] b);
    int sh;
    sh = 56 - 8 * fill_m[2:0];
    blk_m[fill_m[6:3]] = (blk_m[fill_m[6:3]] & ~(64'hff << sh))
                         | (sha512_pkg::word_t'(b) << sh);
    fill_m = fill_m + 7'd1;
  endtask

  task automatic restart_model();
    for (int i = 0; i < 8; i++) hash_m[i] = mode_m ? IV384[i] : IV512[i];
    fill_m = '0;
    len_m = '0;
  endtask

  task automatic absorb_item(sha512_pkg::word_t wd, logic [3:0] nb, logic lst);
    int n, nw;
    digest_item_t d;
    n = (nb > 8) ? 8 : nb;
    for (int k = 0; k < n; k++) begin
      put_byte(wd[63 - 8 * k -: 8]);
      len_m++;
      if (fill_m == 7'd0) fold_block();
    end
    if (lst) begin
      put_byte(8'h80);
      if (fill_m > 7'd112 || fill_m == 7'd0) begin
        while (fill_m != 7'd0) put_byte(8'h00);
        fold_block();
      end
      while (fill_m < 7'd112) put_byte(8'h00);
      blk_m[14] = len_m >> 61;
      blk_m[15] = len_m << 3;
      fold_block();
      fill_m = '0;
      nw = mode_m ? 6 : 8;
      for (int k = 0; k < nw; k++) begin
        d.dword = hash_m[k];
        d.idx = k[2:0];
        d.done = (k + 1 == nw);
        digest_q.push_back(d);
      end
      messages++;
      restart_model();
    end
  endtask

  // receiver
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= snk_idle);
      if (out_ch.valid && out_ch.ready) begin
        digests_seen++;
        if (digest_q.size() == 0) begin
          errors++;
          $display("%0t unexpected digest item: expected none actual %h idx %0d done %b", $time,
                   out_ch.digest_word, out_ch.word_index, out_ch.digest_done);
        end else begin
          if (digest_q[0].dword !== out_ch.digest_word) begin
            errors++;
            $display("%0t digest_word expected %h actual %h", $time, digest_q[0].dword,
                     out_ch.digest_word);
          end
          if (digest_q[0].idx !== out_ch.word_index) begin
            errors++;
            $display("%0t word_index expected %0d actual %0d", $time, digest_q[0].idx,
                     out_ch.word_index);
          end
          if (digest_q[0].done !== out_ch.digest_done) begin
            errors++;
            $display("%0t digest_done expected %b actual %b", $time, digest_q[0].done,
                     out_ch.digest_done);
          end
          void'(digest_q.pop_front());
        end
      end
    end
  end

  task automatic send_item(sha512_pkg::word_t wd, logic [3:0] nb, logic lst);
    while (src_idle > 0 && $urandom_range(99) < src_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.msg_word <= wd;
    in_ch.valid_bytes <= nb;
    in_ch.last_word <= lst;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    absorb_item(wd, nb, lst);
    items_sent++;
  endtask

  task automatic drain_wait();
    in_ch.valid <= 1'b0;
    while (digest_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic set_mode(logic m);
    drain_wait();
    cfg_we <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
    mode_m = m;
    restart_model();
    @(posedge clk);
  endtask

  task automatic send_message(int nbytes, logic [3:0] tailnb);
    int left;
    logic [3:0] nb;
    left = nbytes;
    while (left > 8) begin
      nb = ($urandom_range(9) == 0) ? 4'(8 + $urandom_range(7)) : 4'd8;
      send_item({$urandom, $urandom}, nb, 1'b0);
      left -= 8;
    end
    nb = (left == 8 && tailnb > 8) ? tailnb : 4'(left);
    send_item({$urandom, $urandom}, nb, 1'b1);
  endtask

  task automatic test_directed();
    send_item('0, 4'd0, 1'b1);
    send_item('1, 4'd8, 1'b1);
    send_item(64'h6162630000000000, 4'd3, 1'b1);
    send_item('1, 4'd0, 1'b0);
    send_item('1, 4'd15, 1'b0);
    send_item(64'h0123456789abcdef, 4'd9, 1'b1);
    send_item('1, 4'd5, 1'b1);
    send_message(111, 4'd0);
    send_message(112, 4'd0);
    send_message(128, 4'd12);
  endtask

  task automatic test_sha384();
    set_mode(1'b1);
    send_item('0, 4'd0, 1'b1);
    send_item(64'h6162630000000000, 4'd3, 1'b1);
    send_message(120, 4'd0);
  endtask

  task automatic test_mode_restart();
    set_mode(1'b0);
    send_item({$urandom, $urandom}, 4'd8, 1'b0);
    send_item({$urandom, $urandom}, 4'd4, 1'b0);
    in_ch.valid <= 1'b0;
    repeat (200) @(posedge clk);
    set_mode(1'b0);
    send_item(64'h6162630000000000, 4'd3, 1'b1);
  endtask

  task automatic test_random(int count);
    int target, r;
    target = items_sent + count;
    while (items_sent < target) begin
      r = $urandom_range(9);
      if (r == 0) begin
        send_item({$urandom, $urandom}, 4'($urandom), 1'($urandom));
      end else if (r == 1) begin
        send_message($urandom_range(240, 130), 4'($urandom_range(15, 8)));
      end else begin
        send_message($urandom_range(64, 0), 4'($urandom_range(15, 8)));
      end
      if ($urandom_range(19) == 0) set_mode(1'($urandom));
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.msg_word = '0;
    in_ch.valid_bytes = '0;
    in_ch.last_word = 1'b0;
    mode_m = 1'b0;
    for (int i = 0; i < 16; i++) blk_m[i] = '0;
    restart_model();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    src_idle = 7;
    snk_idle = 79;
    test_directed();
    test_sha384();
    test_mode_restart();
    test_random(55);
    drain_wait();
    src_idle = 79;
    snk_idle = 7;
    test_random(55);
    src_idle = 0;
    snk_idle = 0;
    set_mode(1'b1);
    test_random(50);
    set_mode(1'b0);
    test_random(20);
    drain_wait();
    $display("run covered %0d input items, %0d messages, %0d digest items, both modes",
             items_sent, messages, digests_seen);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
